// File: rtl/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types, constants and helper functions for the Mandelbrot
// escape-time unit.
// ----------------------------------------------------------------------------
package mbet_pkg;

	localparam int MAX_ITERATIONS = 30;
	localparam int COORD_BITS     = 12;
	localparam int FRAC_BITS      = 28;

	localparam int CNT_W   = $clog2(MAX_ITERATIONS + 1);
	localparam int WIDE_W  = 66;
	localparam int REG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TOP_EDGE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_STEP     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_BASE = 3'd4;

	// Escape radius squared, 4.0 in the format of the squared magnitude.
	localparam logic [63:0] FOUR_SQ = 64'd4 << (2 * FRAC_BITS);

	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_ITERATIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COORD,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} mbet_state_t;

	typedef struct packed {
		logic load_in;
		logic calc_c;
		logic mul;
		logic step;
		logic load_out;
	} mbet_cmd_t;

	typedef struct packed {
		logic stop;
	} mbet_sts_t;

	function automatic logic signed [WIDE_W-1:0] wide32(input logic signed [31:0] v);
		wide32 = {{(WIDE_W-32){v[31]}}, v};
	endfunction

	function automatic logic signed [WIDE_W-1:0] wide64(input logic signed [63:0] v);
		wide64 = {{(WIDE_W-64){v[63]}}, v};
	endfunction

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-32){1'b0}}, 32'h7fff_ffff};
		lo = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};
		if (v > hi) begin
			sat32 = 32'sh7fff_ffff;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// File: rtl/mbet_ctrl.sv
// ----------------------------------------------------------------------------
// mbet_ctrl
// Controller state machine: sequences pixel load, point setup, the
// multiply and update steps of each iteration, and result hand-off.
// ----------------------------------------------------------------------------
module mbet_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mbet_pkg::mbet_sts_t sts,
	output mbet_pkg::mbet_cmd_t cmd
);

	mbet_pkg::mbet_state_t state_q;
	mbet_pkg::mbet_state_t state_nxt;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbet_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			mbet_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = mbet_pkg::ST_COORD;
				end
			end
			mbet_pkg::ST_COORD: begin
				cmd.calc_c = 1'b1;
				state_nxt  = mbet_pkg::ST_MUL;
			end
			mbet_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = mbet_pkg::ST_UPD;
			end
			mbet_pkg::ST_UPD: begin
				if (sts.stop) begin
					state_nxt = mbet_pkg::ST_DONE;
				end else begin
					cmd.step  = 1'b1;
					state_nxt = mbet_pkg::ST_MUL;
				end
			end
			mbet_pkg::ST_DONE: begin
				// The result register is free once its current item is taken.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = mbet_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mbet_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/mbet_dp.sv
// ----------------------------------------------------------------------------
// mbet_dp
// Datapath: configuration registers, point setup, the shared complex
// squaring unit with its product registers, and the result register.
// ----------------------------------------------------------------------------
module mbet_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbet_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic [mbet_pkg::COORD_BITS-1:0]     pixel_x,
	input  logic [mbet_pkg::COORD_BITS-1:0]     pixel_y,
	input  mbet_pkg::mbet_cmd_t                 cmd,
	output mbet_pkg::mbet_sts_t                 sts,
	output logic [mbet_pkg::COORD_BITS-1:0]     out_x,
	output logic [mbet_pkg::COORD_BITS-1:0]     out_y,
	output logic [4:0]                          iteration_count,
	output logic [31:0]                         pixel_value
);

	localparam int W  = mbet_pkg::WIDE_W;
	localparam int CB = mbet_pkg::COORD_BITS;

	logic signed [31:0] left_q;
	logic signed [31:0] top_q;
	logic [30:0]        xstep_q;
	logic [30:0]        ystep_q;
	logic [31:0]        cbase_q;

	logic [CB-1:0]              px_q;
	logic [CB-1:0]              py_q;
	logic signed [31:0]         cx_q;
	logic signed [31:0]         cy_q;
	logic signed [31:0]         zx_q;
	logic signed [31:0]         zy_q;
	logic [mbet_pkg::CNT_W-1:0] count_q;

	logic signed [63:0] sxx_s1;
	logic signed [63:0] syy_s1;
	logic signed [63:0] sxy_s1;

	logic [CB-1:0]      out_x_q;
	logic [CB-1:0]      out_y_q;
	logic [4:0]         iter_q;
	logic [31:0]        pix_q;

	logic [CB+30:0]       xprod;
	logic [CB+30:0]       yprod;
	logic signed [W-1:0]  xsum;
	logic signed [W-1:0]  ysum;
	logic [63:0]          mag;
	logic signed [W-1:0]  nx_sum;
	logic signed [W-1:0]  ny_sum;
	logic signed [W-1:0]  nx_sh;
	logic signed [W-1:0]  ny_sh;

	// Configuration registers; the user must write them only while the unit is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= -32'sd536870912;
			top_q   <= -32'sd402653184;
			xstep_q <= '0;
			ystep_q <= '0;
			cbase_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbet_pkg::REG_LEFT_EDGE:  left_q  <= cfg_data;
				mbet_pkg::REG_TOP_EDGE:   top_q   <= cfg_data;
				mbet_pkg::REG_X_STEP:     xstep_q <= cfg_data[30:0];
				mbet_pkg::REG_Y_STEP:     ystep_q <= cfg_data[30:0];
				mbet_pkg::REG_COLOR_BASE: cbase_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Point setup: c = pixel * step + edge, clamped.
	assign xprod = (CB+31)'(px_q) * (CB+31)'(xstep_q);
	assign yprod = (CB+31)'(py_q) * (CB+31)'(ystep_q);
	assign xsum  = {{(W-CB-31){1'b0}}, xprod} + mbet_pkg::wide32(left_q);
	assign ysum  = {{(W-CB-31){1'b0}}, yprod} + mbet_pkg::wide32(top_q);

	// Escape test and next z, all from the registered products of the current z.
	assign mag    = 64'(sxx_s1) + 64'(syy_s1);
	assign nx_sum = mbet_pkg::wide64(sxx_s1) - mbet_pkg::wide64(syy_s1)
		+ (mbet_pkg::wide32(cx_q) <<< mbet_pkg::FRAC_BITS);
	assign ny_sum = mbet_pkg::wide64(sxy_s1)
		+ (mbet_pkg::wide32(cy_q) <<< (mbet_pkg::FRAC_BITS - 1));
	assign nx_sh  = nx_sum >>> mbet_pkg::FRAC_BITS;
	assign ny_sh  = ny_sum >>> (mbet_pkg::FRAC_BITS - 1);

	assign sts.stop = (mag >= mbet_pkg::FOUR_SQ) || (count_q >= mbet_pkg::COUNT_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			zx_q    <= '0;
			zy_q    <= '0;
			count_q <= '0;
		end
		if (cmd.calc_c) begin
			cx_q <= mbet_pkg::sat32(xsum);
			cy_q <= mbet_pkg::sat32(ysum);
		end
		if (cmd.mul) begin
			sxx_s1 <= 64'(zx_q) * 64'(zx_q);
			syy_s1 <= 64'(zy_q) * 64'(zy_q);
			sxy_s1 <= 64'(zx_q) * 64'(zy_q);
		end
		if (cmd.step) begin
			zx_q    <= mbet_pkg::sat32(nx_sh);
			zy_q    <= mbet_pkg::sat32(ny_sh);
			count_q <= count_q + mbet_pkg::CNT_W'(1);
		end
		if (cmd.load_out) begin
			out_x_q <= px_q;
			out_y_q <= py_q;
			iter_q  <= 5'(count_q);
			pix_q   <= 32'({count_q, 3'b000}) + cbase_q;
		end
	end

	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign iteration_count = iter_q;
	assign pixel_value     = pix_q;

endmodule

// File: rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time evaluation of one pixel of the Mandelbrot set in Q4.28 fixed
// point.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time. After an item is accepted, the COORD
// state forms the point c, then each iteration takes two states through the
// single shared squaring unit (MUL forms three 32x32 products, then UPD makes
// the escape test and the clamped update), and DONE hands the result to the
// output register once it is free. The limit is thirty iterations. The output
// register lets a new pixel start while the previous result waits to be taken.
module mandelbrot_escape_time (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbet_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mbet_pkg::COORD_BITS-1:0]     pixel_x,
	input  logic [mbet_pkg::COORD_BITS-1:0]     pixel_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mbet_pkg::COORD_BITS-1:0]     out_x,
	output logic [mbet_pkg::COORD_BITS-1:0]     out_y,
	output logic [4:0]                          iteration_count,
	output logic [31:0]                         pixel_value
);

	mbet_pkg::mbet_cmd_t cmd;
	mbet_pkg::mbet_sts_t sts;

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbet_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.cmd             (cmd),
		.sts             (sts),
		.out_x           (out_x),
		.out_y           (out_y),
		.iteration_count (iteration_count),
		.pixel_value     (pixel_value)
	);

`ifndef NO_ASSERTIONS
	// Only one pixel is in flight: acceptance closes the input side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a pixel is in flight");

	// An iteration step is never taken once the escape or limit test fails.
	a_no_step_past_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.stop)
		else $error("iteration step issued after stop condition");

	// The result register is never overwritten while it holds an untaken item.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// The reported count never exceeds the iteration limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iteration_count <= 5'(mbet_pkg::MAX_ITERATIONS)))
		else $error("iteration count above limit");
`endif

endmodule

// File: tb/sv/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Self-checking testbench for the Mandelbrot escape-time unit. A queue-fed
// driver sends pixel coordinates in random bursts, a monitor takes results
// under random back-pressure, and a fixed-point predictor of the escape-time
// iteration fills a queue of expected pixels that every result is checked against.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;

	import mbet_pkg::*;

	localparam int ITER_LIMIT = 30;
	localparam int FRAC = 28;
	localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC);
	localparam longint Q_ONE = longint'(1) << FRAC;
	localparam int PHASE_ITEMS = 180;
	localparam int RANDOM_PHASES = 8;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} pixel_coord_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [4:0]            count;
		logic [31:0]           value;
	} pixel_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [COORD_BITS-1:0] pixel_x = '0;
	logic [COORD_BITS-1:0] pixel_y = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [COORD_BITS-1:0] out_x;
	logic [COORD_BITS-1:0] out_y;
	logic [4:0]            iteration_count;
	logic [31:0]           pixel_value;

	// Window registers as the block should hold them.
	logic signed [31:0] win_left = -32'sd536870912;
	logic signed [31:0] win_top = -32'sd402653184;
	logic [30:0]        col_step = '0;
	logic [30:0]        row_step = '0;
	logic [31:0]        shade_base = '0;

	pixel_coord_t  pixel_queue[$];
	pixel_result_t expected_pixels[$];
	pixel_coord_t  send_item;
	pixel_result_t got_pixel;
	pixel_result_t want_pixel;
	int            mismatch_count = 0;
	int            send_gap = 0;
	int            burst_left = 0;
	int            stall_left = 0;
	int            ready_left = 0;

	mandelbrot_escape_time i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_x          (out_x),
		.out_y          (out_y),
		.iteration_count(iteration_count),
		.pixel_value    (pixel_value)
	);

	always #2 clk = ~clk;

	function automatic longint clamp_s32(input longint v);
		if (v > longint'(32'sh7fff_ffff)) begin
			return longint'(32'sh7fff_ffff);
		end else if (v < -longint'(64'h8000_0000)) begin
			return -longint'(64'h8000_0000);
		end
		return v;
	endfunction

	// Escape-time iteration in Q4.28; the shifts of signed values round toward
	// minus infinity.
	function automatic pixel_result_t evaluate_pixel(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		pixel_result_t res;
		longint        c_re;
		longint        c_im;
		longint        z_re;
		longint        z_im;
		longint        sq_re;
		longint        sq_im;
		logic [63:0]   mag;
		int            n;
		bit            running;
		c_re = clamp_s32(longint'(px) * longint'(col_step) + longint'(win_left));
		c_im = clamp_s32(longint'(py) * longint'(row_step) + longint'(win_top));
		z_re = 0;
		z_im = 0;
		n = 0;
		running = 1'b1;
		while (running) begin
			sq_re = z_re * z_re;
			sq_im = z_im * z_im;
			mag = sq_re + sq_im;
			if (mag >= ESCAPE_MAG || n >= ITER_LIMIT) begin
				running = 1'b0;
			end else begin
				sq_re = clamp_s32((sq_re - sq_im + c_re * Q_ONE) >>> FRAC);
				z_im = clamp_s32((z_re * z_im + c_im * (Q_ONE / 2)) >>> (FRAC - 1));
				z_re = sq_re;
				n++;
			end
		end
		res.x = px;
		res.y = py;
		res.count = 5'(n);
		res.value = 32'(n) * 32'd8 + shade_base;
		return res;
	endfunction

	task automatic note_mismatch(input string what, input pixel_result_t want,
			input pixel_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected x=%0d y=%0d count=%0d value=%h,",
				$realtime, what, want.x, want.y, want.count, want.value,
				" got x=%0d y=%0d count=%0d value=%h",
				got.x, got.y, got.count, got.value);
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_pixels.push_back(evaluate_pixel(pixel_x, pixel_y));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					send_item = pixel_queue.pop_front();
					in_valid <= 1'b1;
					pixel_x <= send_item.x;
					pixel_y <= send_item.y;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
							$urandom_range(1, 80);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a stall of random length, then a run of ready cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (ready_left > 0) begin
			ready_left--;
			out_ready <= 1'b1;
		end else begin
			ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 30);
			stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 90) :
				$urandom_range(0, 6);
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_pixel = '{x: out_x, y: out_y, count: iteration_count, value: pixel_value};
			if (expected_pixels.size() == 0) begin
				note_mismatch("unexpected result", '0, got_pixel);
			end else begin
				want_pixel = expected_pixels.pop_front();
				if (got_pixel.x !== want_pixel.x || got_pixel.y !== want_pixel.y ||
						got_pixel.count !== want_pixel.count ||
						got_pixel.value !== want_pixel.value) begin
					note_mismatch("result mismatch", want_pixel, got_pixel);
				end
			end
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_LEFT_EDGE:  win_left = data;
			REG_TOP_EDGE:   win_top = data;
			REG_X_STEP:     col_step = data[30:0];
			REG_Y_STEP:     row_step = data[30:0];
			REG_COLOR_BASE: shade_base = data;
			default: begin
			end
		endcase
	endtask

	task automatic program_window(input logic [31:0] left, input logic [31:0] top,
			input logic [31:0] xs, input logic [31:0] ys, input logic [31:0] base);
		write_reg(REG_LEFT_EDGE, left);
		write_reg(REG_TOP_EDGE, top);
		write_reg(REG_X_STEP, xs);
		write_reg(REG_Y_STEP, ys);
		write_reg(REG_COLOR_BASE, base);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_pixel(input int x, input int y);
		pixel_queue.push_back('{x: COORD_BITS'(x), y: COORD_BITS'(y)});
	endtask

	// The test sequence waits here until every expected result has been taken.
	// The check runs on the falling edge, when the driver's updates have settled.
	task automatic wait_idle();
		while (pixel_queue.size() != 0 || expected_pixels.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [31:0] step_x;
		logic [31:0] step_y;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset window: both steps are zero, so every pixel lands on the corner.
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		queue_pixel(4095, 0);
		wait_idle();

		// The top bit of a step is dropped, and writes past the last register
		// are ignored. c = -1 stays bounded; the color base wraps.
		program_window(32'hF000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFF8);
		for (int idx = int'(REG_COLOR_BASE) + 1; idx < (1 << REG_IDX_W); idx++) begin
			write_reg(REG_IDX_W'(idx), $urandom());
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_pixel(0, 0);
		queue_pixel(0, 4095);
		queue_pixel(1, 0);
		queue_pixel(4095, 4095);
		wait_idle();

		// Extreme edges and steps: the point saturates on both axes.
		program_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		queue_pixel(0, 0);
		queue_pixel(1, 1);
		queue_pixel(4095, 4095);
		queue_pixel(4095, 0);
		wait_idle();
		program_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF);
		queue_pixel(0, 0);
		queue_pixel(0, 4095);
		queue_pixel(4095, 0);
		wait_idle();

		// Classic window over [-2, 1] x [-1.5, 1.5]: an escape with |z|^2 exactly
		// four, points near zero that reach the limit, and the boundary.
		program_window(32'hE000_0000, 32'hE800_0000, 32'h0003_0000, 32'h0003_0000, 32'h100);
		queue_pixel(0, 2048);
		queue_pixel(2730, 2048);
		queue_pixel(1365, 2048);
		queue_pixel(1000, 1500);
		queue_pixel(3000, 3000);
		queue_pixel(2500, 1200);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 3) begin
				program_window($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			end else if (phase == 5) begin
				// Zoom onto the set boundary, where counts are deep and varied.
				step_x = $urandom_range(1, 1024);
				step_y = $urandom_range(1, 1024);
				program_window(32'hF400_0000 - $urandom_range(0, 32'h0080_0000),
					32'h0180_0000 + $urandom_range(0, 32'h0080_0000), step_x, step_y,
					$urandom());
			end else begin
				step_x = $urandom_range(32'h100, 32'h4_0000);
				step_y = $urandom_range(32'h100, 32'h4_0000);
				program_window(32'hE000_0000 + $urandom_range(0, 32'h1000_0000) -
						32'h0800_0000,
					32'hE800_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000,
					step_x, step_y, $urandom());
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			wait_idle();
		end

		repeat (70) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
